### sv/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg: shared types and constants for the button press classifier
// Holds register indexes, alarm codes, the config bundle and the event bundles.
// ----------------------------------------------------------------------------
package bpdc_pkg;

    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // Alarm state codes
    localparam logic [1:0] ALARM_IDLE    = 2'd0;
    localparam logic [1:0] ALARM_RINGING = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] RST_REPEAT_TIME   = 8'd20;
    localparam logic [CNT_W-1:0] RST_HOLD_TIME     = 8'd200;
    localparam logic [CNT_W-1:0] RST_POLL_PERIOD   = 8'd5;
    localparam logic [CNT_W-1:0] RST_REPORT_PERIOD = 8'd30;

    typedef struct packed {
        logic [CNT_W-1:0] repeat_time;
        logic [CNT_W-1:0] hold_time;
        logic [CNT_W-1:0] poll_period;
        logic [CNT_W-1:0] report_period;
    } t_cfg;

    typedef struct packed {
        logic up_event;
        logic down_event;
        logic skip_event;
        logic pause_event;
        logic cancel_event;
    } t_btn_events;

    typedef struct packed {
        logic poll_tick;
        logic report_tick;
    } t_div_events;

    // Saturating increment of a press or phase counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

### sv/bpdc_buttons.sv
// ----------------------------------------------------------------------------
// bpdc_buttons: press-time counters for the up, down and third buttons
// Advances all three counters on each step and flags the events they cause.
// ----------------------------------------------------------------------------
module bpdc_buttons import bpdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_cfg        i_cfg,
    input  logic        i_up_level_n,
    input  logic        i_down_level_n,
    input  logic        i_skip_level_n,
    input  logic [1:0]  i_alarm_state,
    output t_btn_events o_events
);

    logic [CNT_W-1:0] r_up_count,   n_up_count;
    logic [CNT_W-1:0] r_down_count, n_down_count;
    logic [CNT_W-1:0] r_third_count, n_third_count;
    logic [CNT_W-1:0] up_inc, down_inc, third_inc;

    always_comb begin
        up_inc    = sat_inc(r_up_count);
        down_inc  = sat_inc(r_down_count);
        third_inc = sat_inc(r_third_count);
        o_events  = '0;

        // Up: repeat only while idle, cancel only while ringing
        if (!i_up_level_n) begin
            n_up_count = up_inc;
            if (up_inc >= i_cfg.repeat_time && i_alarm_state == ALARM_IDLE) begin
                o_events.up_event = 1'b1;
                n_up_count        = '0;
            end
            if (up_inc >= i_cfg.hold_time && i_alarm_state == ALARM_RINGING) begin
                o_events.cancel_event = 1'b1;
            end
        end else begin
            n_up_count = '0;
        end

        if (!i_down_level_n) begin
            n_down_count = down_inc;
            if (down_inc >= i_cfg.repeat_time) begin
                o_events.down_event = 1'b1;
                n_down_count        = '0;
            end
        end else begin
            n_down_count = '0;
        end

        // Third: skip on long hold, pause on release after a press of at least the repeat time
        if (!i_skip_level_n) begin
            n_third_count = third_inc;
            if (third_inc >= i_cfg.hold_time) begin
                o_events.skip_event = 1'b1;
                n_third_count       = '0;
            end
        end else begin
            o_events.pause_event = (r_third_count >= i_cfg.repeat_time);
            n_third_count        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_count    <= '0;
            r_down_count  <= '0;
            r_third_count <= '0;
        end else if (i_step) begin
            r_up_count    <= n_up_count;
            r_down_count  <= n_down_count;
            r_third_count <= n_third_count;
        end
    end

endmodule

### sv/bpdc_div.sv
// ----------------------------------------------------------------------------
// bpdc_div: millisecond divider for poll and report ticks
// A report tick restarts both phases.
// ----------------------------------------------------------------------------
module bpdc_div import bpdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_cfg        i_cfg,
    output t_div_events o_events
);

    logic [CNT_W-1:0] r_poll_phase,   n_poll_phase;
    logic [CNT_W-1:0] r_report_phase, n_report_phase;
    logic [CNT_W-1:0] poll_inc, report_inc;

    always_comb begin
        poll_inc             = sat_inc(r_poll_phase);
        report_inc           = sat_inc(r_report_phase);
        o_events.poll_tick   = (poll_inc >= i_cfg.poll_period);
        o_events.report_tick = (report_inc >= i_cfg.report_period);
        n_poll_phase   = (o_events.poll_tick || o_events.report_tick) ? '0 : poll_inc;
        n_report_phase = o_events.report_tick ? '0 : report_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_phase   <= '0;
            r_report_phase <= '0;
        end else if (i_step) begin
            r_poll_phase   <= n_poll_phase;
            r_report_phase <= n_report_phase;
        end
    end

endmodule

### sv/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier: per-millisecond button event classifier
// A result beat is valid in the cycle after its accepted tick beat. One tick
// beat per cycle under a ready sink; the counter update is a single saturating
// increment and compare, and the output register holds the result.
// Reset (synchronous, active low): counters and phases clear, registers take
// their defaults (20, 200, 5, 30), and the output register empties.
// ----------------------------------------------------------------------------
module button_press_duration_classifier import bpdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Tick input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_up_level_n,
    input  logic                 i_down_level_n,
    input  logic                 i_skip_level_n,
    input  logic [1:0]           i_alarm_state,

    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_up_event,
    output logic                 o_down_event,
    output logic                 o_skip_event,
    output logic                 o_pause_event,
    output logic                 o_cancel_event,
    output logic                 o_poll_tick,
    output logic                 o_report_tick,

    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg        r_cfg;
    t_btn_events btn_events;
    t_div_events div_events;
    logic        in_beat;
    logic        r_out_valid;
    t_btn_events r_btn_events;
    t_div_events r_div_events;

    // Configuration writes are always taken; the block is idle by contract.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_time   <= RST_REPEAT_TIME;
            r_cfg.hold_time     <= RST_HOLD_TIME;
            r_cfg.poll_period   <= RST_POLL_PERIOD;
            r_cfg.report_period <= RST_REPORT_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REPEAT_TIME:   r_cfg.repeat_time   <= i_cfg_data;
                REG_HOLD_TIME:     r_cfg.hold_time     <= i_cfg_data;
                REG_POLL_PERIOD:   r_cfg.poll_period   <= i_cfg_data;
                REG_REPORT_PERIOD: r_cfg.report_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a new tick whenever the output register is empty or draining
    // this cycle, so ticks flow one per cycle under a ready sink.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // State advances exactly on an accepted tick beat.
    bpdc_buttons u_buttons (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_beat),
        .i_cfg          (r_cfg),
        .i_up_level_n   (i_up_level_n),
        .i_down_level_n (i_down_level_n),
        .i_skip_level_n (i_skip_level_n),
        .i_alarm_state  (i_alarm_state),
        .o_events       (btn_events)
    );

    bpdc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_beat),
        .i_cfg    (r_cfg),
        .o_events (div_events)
    );

    // Output register: load on a tick beat, drop valid once the sink takes
    // the result beat, hold the payload while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_btn_events <= btn_events;
            r_div_events <= div_events;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_up_event     = r_btn_events.up_event;
    assign o_down_event   = r_btn_events.down_event;
    assign o_skip_event   = r_btn_events.skip_event;
    assign o_pause_event  = r_btn_events.pause_event;
    assign o_cancel_event = r_btn_events.cancel_event;
    assign o_poll_tick    = r_div_events.poll_tick;
    assign o_report_tick  = r_div_events.report_tick;

endmodule

### sv/bpdc_checker.sv
// ----------------------------------------------------------------------------
// bpdc_checker: port-level checks for the button press classifier
// Watches the handshakes and event combinations seen at the top level.
// ----------------------------------------------------------------------------
module bpdc_checker import bpdc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_up_event,
    input logic o_down_event,
    input logic o_skip_event,
    input logic o_pause_event,
    input logic o_cancel_event,
    input logic o_poll_tick,
    input logic o_report_tick
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_up_event)
            && $stable(o_down_event) && $stable(o_skip_event)
            && $stable(o_pause_event) && $stable(o_cancel_event)
            && $stable(o_poll_tick) && $stable(o_report_tick))
        else $error("stalled result beat changed or dropped");

    // Every tick beat produces a result beat in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("tick beat gave no result beat");

    // An empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // Up repeat needs an idle alarm, cancel needs a ringing one
    a_up_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_up_event && o_cancel_event))
        else $error("up repeat and cancel in the same tick");

    // Skip needs the button held, pause needs it released
    a_skip_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_skip_event && o_pause_event))
        else $error("skip and pause in the same tick");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (.*);
